// ===== hdl/bchd_pkg.sv =====
// Shared types and constants for the button click/hold detector.
package bchd_pkg;

	localparam int CFG_W = 16;
	localparam int HOLD_W = 24;
	localparam int COUNT_W = 8;

	// register indexes on the configuration port
	localparam logic [1:0] REG_CLICK_WINDOW = 2'd0;
	localparam logic [1:0] REG_HOLD_THRESH = 2'd1;
	localparam logic [1:0] REG_COUNT_LIMIT = 2'd2;

	localparam logic [15:0] CLICK_WINDOW_RST = 16'd400;
	localparam logic [15:0] HOLD_THRESH_RST = 16'd400;
	localparam logic [7:0] COUNT_LIMIT_RST = 8'd8;

	// event codes
	localparam logic [1:0] EV_DOWN = 2'd0;
	localparam logic [1:0] EV_UP = 2'd1;
	localparam logic [1:0] EV_CLICK = 2'd2;
	localparam logic [1:0] EV_HOLD = 2'd3;

	// input command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LEVEL = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	typedef struct packed {
		logic command;
		logic level;
	} in_word_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [COUNT_W-1:0] num_presses;
		logic [HOLD_W-1:0] hold_ms;
		logic last;
	} out_word_t;

	// results of one input word: how many (0..2) and the words themselves
	typedef struct packed {
		logic [1:0] n;
		out_word_t w0;
		out_word_t w1;
	} res_push_t;

endpackage

// ===== hdl/bchd_core.sv =====
// Gesture state registers, configuration registers and event generation.
module bchd_core #(
	parameter int TIME_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic in_accept,
	input bchd_pkg::in_word_t in_word,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [bchd_pkg::CFG_W-1:0] cfg_data,
	output bchd_pkg::res_push_t push
);
	import bchd_pkg::*;

	localparam int CW = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	logic [15:0] click_window_q;
	logic [15:0] hold_thresh_q;
	logic [7:0] count_limit_q;

	logic held_q;
	logic window_open_q;
	logic [15:0] window_left_q;
	logic [7:0] press_count_q;
	logic [TIME_BITS-1:0] since_press_q;
	logic press_seen_q;

	logic held_d;
	logic window_open_d;
	logic [15:0] window_left_d;
	logic [7:0] press_count_d;
	logic [TIME_BITS-1:0] since_press_d;
	logic press_seen_d;

	logic [CW-1:0] since_ext;
	logic [HOLD_W-1:0] hold_val;
	logic hold_reached;
	logic may_count;
	out_word_t w_down, w_up, w_click, w_hold;

	always_comb begin
		since_ext = CW'(since_press_q);
		hold_val = (since_ext > CW'({HOLD_W{1'b1}})) ? {HOLD_W{1'b1}} : since_ext[HOLD_W-1:0];
		hold_reached = press_seen_q && (since_ext >= CW'(hold_thresh_q));
		may_count = ((count_limit_q == 8'd0) || (press_count_q < count_limit_q))
			&& (press_count_q != 8'hFF);
	end

	always_comb begin
		w_down = '{event_kind: EV_DOWN, num_presses: '0, hold_ms: '0, last: 1'b1};
		w_click = '{event_kind: EV_CLICK, num_presses: press_count_q, hold_ms: '0,
			last: 1'b1};
		w_up = '{event_kind: EV_UP, num_presses: '0, hold_ms: '0, last: !hold_reached};
		w_hold = '{event_kind: EV_HOLD, num_presses: press_count_q, hold_ms: hold_val,
			last: 1'b1};
	end

	always_comb begin
		held_d = held_q;
		window_open_d = window_open_q;
		window_left_d = window_left_q;
		press_count_d = press_count_q;
		since_press_d = since_press_q;
		press_seen_d = press_seen_q;
		push = '0;
		if (in_accept) begin
			if (in_word.command == CMD_TICK) begin
				if (since_press_q != TIME_MAX)
					since_press_d = since_press_q + 1'b1;
				if (window_open_q) begin
					// a window of zero closes on the next tick, same as one
					if (window_left_q <= 16'd1) begin
						window_left_d = '0;
						window_open_d = 1'b0;
						if (!held_q) begin
							push.n = 2'd1;
							push.w0 = w_click;
						end
					end else begin
						window_left_d = window_left_q - 1'b1;
					end
				end
			end else if (in_word.level) begin
				held_d = 1'b1;
				push.n = 2'd1;
				push.w0 = w_down;
				if (!window_open_q) begin
					press_count_d = 8'd1;
					window_open_d = 1'b1;
				end else if (may_count) begin
					press_count_d = press_count_q + 1'b1;
				end
				window_left_d = click_window_q;
				since_press_d = '0;
				press_seen_d = 1'b1;
			end else if (held_q) begin
				held_d = 1'b0;
				push.w0 = w_up;
				push.w1 = w_hold;
				push.n = hold_reached ? 2'd2 : 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_window_q <= CLICK_WINDOW_RST;
			hold_thresh_q <= HOLD_THRESH_RST;
			count_limit_q <= COUNT_LIMIT_RST;
			held_q <= 1'b0;
			window_open_q <= 1'b0;
			window_left_q <= '0;
			press_count_q <= '0;
			since_press_q <= '0;
			press_seen_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CLICK_WINDOW: click_window_q <= cfg_data;
					REG_HOLD_THRESH: hold_thresh_q <= cfg_data;
					REG_COUNT_LIMIT: count_limit_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			held_q <= held_d;
			window_open_q <= window_open_d;
			window_left_q <= window_left_d;
			press_count_q <= press_count_d;
			since_press_q <= since_press_d;
			press_seen_q <= press_seen_d;
		end
	end

	a_count_nonzero_open: assert property (@(posedge clk) disable iff (!arst_n)
		window_open_q |-> press_count_q != 8'd0)
		else $error("window open with zero press count");
	a_press_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_word.command == CMD_LEVEL && in_word.level)
		|=> held_q && window_open_q && since_press_q == '0)
		else $error("press did not restart timers");
	a_hold_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> held_q && in_word.command == CMD_LEVEL && !in_word.level)
		else $error("hold event without a release");

endmodule

// ===== hdl/bchd_outq.sv =====
// Result queue: takes up to two words a cycle, hands out one a cycle while out_stall is low.
module bchd_outq (
	input logic clk,
	input logic arst_n,
	input bchd_pkg::res_push_t push,
	output logic full,
	output logic out_valid,
	input logic out_stall,
	output bchd_pkg::out_word_t out_data
);
	import bchd_pkg::*;

	out_word_t mem_q [QDEPTH];
	logic [QAW-1:0] head_q, tail_q;
	logic [QAW:0] count_q;
	logic pop;
	logic [QAW-1:0] tail_p1;

	assign out_valid = count_q != '0;
	assign out_data = mem_q[head_q];
	assign pop = out_valid && !out_stall;
	assign tail_p1 = tail_q + 1'b1;
	// accept only while two free slots remain
	assign full = count_q > (QAW+1)'(QDEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[tail_q] <= push.w0;
		if (push.n == 2'd2)
			mem_q[tail_p1] <= push.w1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (pop)
				head_q <= head_q + 1'b1;
			tail_q <= tail_q + QAW'(push.n);
			count_q <= count_q + (QAW+1)'(push.n) - (QAW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH))
		else $error("result queue overflow");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.n == 2'd0) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop on pop");
	a_last_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> !push.w0.last && push.w1.last)
		else $error("last flag misplaced in word pair");

endmodule

// ===== hdl/button_click_hold_detector_unit.sv =====
// Button click/hold detector: top level.
// Input channel in_valid/in_stall/in_data carries one word per tick or per
// button level report (command 0 = millisecond tick, 1 = level report).
// Output channel out_valid/out_stall/out_data gives gesture events: DOWN,
// UP, CLICK with press count, HOLD with press length; last marks the final
// event caused by one input word. An input word yields zero, one or two.
// Events of an accepted word are written into the result queue at the edge
// that accepts it; with the queue empty, the first is on the output after it.
// Throughput: one input word per cycle while the four-entry result queue
// has two free slots; the output drains one event per cycle while out_stall
// is low, so a burst of two-event words runs at the output rate.
// Output stall: events wait in the queue; in_stall rises once fewer than
// two slots are free and no input is lost.
// Configuration: cfg_we/cfg_index/cfg_data write click window, hold
// threshold and count limit; write only while the block is idle.
// Reset clears gesture state and queue and loads 400 ms, 400 ms and 8.
module button_click_hold_detector_unit #(
	parameter int TIME_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input bchd_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output bchd_pkg::out_word_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [bchd_pkg::CFG_W-1:0] cfg_data
);
	import bchd_pkg::*;

	logic in_accept;
	logic full;
	res_push_t push;

	assign in_stall = full;
	assign in_accept = in_valid && !full;

	bchd_core #(.TIME_BITS(TIME_BITS)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_accept(in_accept),
		.in_word(in_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push)
	);

	bchd_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the button click/hold detector.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bchd_pkg::*;

	// press timer narrower than the default build
	localparam int TB_TIME_BITS = 16;
	localparam int SETTLE = 8;
	localparam longint LIMIT = 1_000_000;
	localparam int PREDICTED = -1;
	localparam int RAND_PHASES = 5;
	localparam int PHASE_WORDS = 30;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic cmd;
		logic lvl;
		int unsigned reps;
		int typed;
		out_word_t e0;
		out_word_t e1;
		logic [1:0] reg_idx;
		logic [CFG_W-1:0] reg_val;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	button_click_hold_detector_unit #(
		.TIME_BITS(TB_TIME_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// gesture state mirror
	logic held_q = 1'b0;
	logic win_open_q = 1'b0;
	logic [15:0] win_left_q = '0;
	logic [7:0] presses_q = '0;
	logic [TB_TIME_BITS-1:0] since_q = '0;
	logic seen_q = 1'b0;
	logic [15:0] win_cfg = CLICK_WINDOW_RST;
	logic [15:0] thr_cfg = HOLD_THRESH_RST;
	logic [7:0] cap_cfg = COUNT_LIMIT_RST;

	out_word_t expected_events[$];
	script_row_t gesture_script[$];

	// expectation attached to the word currently on the input
	int cur_typed = PREDICTED;
	out_word_t cur_e0 = '0;
	out_word_t cur_e1 = '0;

	bit quiet = 1'b0;
	int unsigned stall_run = 0;
	int unsigned stall_pick;
	int unsigned errors = 0;
	int unsigned words_sent = 0;
	int unsigned reg_writes = 0;
	int unsigned events_checked = 0;
	int unsigned clicks_seen = 0;
	int unsigned holds_seen = 0;
	longint cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic out_word_t gesture_event(input logic [1:0] kind, input logic [7:0] cnt,
			input logic [HOLD_W-1:0] dur, input logic fin);
		out_word_t e;
		e.event_kind = kind;
		e.num_presses = cnt;
		e.hold_ms = dur;
		e.last = fin;
		return e;
	endfunction

	function automatic script_row_t word_row(input logic cmd, input logic lvl,
			input int unsigned reps);
		script_row_t r;
		r = '{ROW_WORD, cmd, lvl, reps, PREDICTED, '0, '0, '0, '0};
		return r;
	endfunction

	function automatic script_row_t typed_row(input logic cmd, input logic lvl, input int n,
			input out_word_t e0, input out_word_t e1);
		script_row_t r;
		r = '{ROW_WORD, cmd, lvl, 1, n, e0, e1, '0, '0};
		return r;
	endfunction

	function automatic script_row_t reg_row(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		script_row_t r;
		r = '{ROW_REG, 1'b0, 1'b0, 0, PREDICTED, '0, '0, idx, val};
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] draw_setting(input logic [1:0] idx);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (idx)
			REG_CLICK_WINDOW: return CFG_W'((r < 10) ? 0 : (r < 20) ? 1 :
				(r < 25) ? 16'hFFFF : $urandom_range(2, 25));
			REG_HOLD_THRESH: return CFG_W'((r < 15) ? 0 : (r < 20) ? 16'hFFFF :
				$urandom_range(1, 30));
			default: return CFG_W'((r < 20) ? 0 : (r < 30) ? 255 : (r < 40) ? 1 :
				$urandom_range(2, 6));
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void predict_gesture(input in_word_t w, output int n,
			output out_word_t r0, output out_word_t r1);
		logic [63:0] dur;
		n = 0;
		r0 = '0;
		r1 = '0;
		if (w.command == CMD_TICK) begin
			if (since_q != '1)
				since_q = since_q + 1'b1;
			if (win_open_q) begin
				if (win_left_q <= 16'd1) begin
					win_left_q = '0;
					win_open_q = 1'b0;
					// window closing while held gives nothing
					if (!held_q) begin
						r0 = gesture_event(EV_CLICK, presses_q, '0, 1'b1);
						n = 1;
					end
				end else begin
					win_left_q = win_left_q - 1'b1;
				end
			end
		end else if (w.level) begin
			held_q = 1'b1;
			r0 = gesture_event(EV_DOWN, '0, '0, 1'b1);
			n = 1;
			if (!win_open_q) begin
				presses_q = 8'd1;
				win_open_q = 1'b1;
			end else if ((cap_cfg == 8'd0 || presses_q < cap_cfg) && presses_q != 8'hFF) begin
				presses_q = presses_q + 1'b1;
			end
			win_left_q = win_cfg;
			since_q = '0;
			seen_q = 1'b1;
		end else if (held_q) begin
			held_q = 1'b0;
			r0 = gesture_event(EV_UP, '0, '0, 1'b1);
			n = 1;
			if (seen_q && since_q >= thr_cfg) begin
				dur = 64'(since_q);
				r0.last = 1'b0;
				r1 = gesture_event(EV_HOLD, presses_q,
					(dur > 64'hFFFFFF) ? 24'hFFFFFF : dur[HOLD_W-1:0], 1'b1);
				n = 2;
			end
		end
	endfunction

	// sample both channels and the register port at the rising edge
	always @(posedge clk) begin : monitor
		int n;
		out_word_t p0, p1, want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CLICK_WINDOW: win_cfg = cfg_data;
					REG_HOLD_THRESH: thr_cfg = cfg_data;
					REG_COUNT_LIMIT: cap_cfg = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					errors++;
					$display("%0t: unexpected word: kind %0d count %0d hold %0d last %0d",
						$realtime, out_data.event_kind, out_data.num_presses,
						out_data.hold_ms, out_data.last);
				end else begin
					want = expected_events.pop_front();
					events_checked++;
					if (out_data.event_kind !== want.event_kind ||
							out_data.num_presses !== want.num_presses ||
							out_data.hold_ms !== want.hold_ms || out_data.last !== want.last) begin
						errors++;
						$display("%0t: kind/count/hold/last expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
							$realtime, want.event_kind, want.num_presses, want.hold_ms,
							want.last, out_data.event_kind, out_data.num_presses,
							out_data.hold_ms, out_data.last);
					end
					if (want.event_kind == EV_CLICK)
						clicks_seen++;
					if (want.event_kind == EV_HOLD)
						holds_seen++;
				end
			end
			if (in_valid && !in_stall) begin
				predict_gesture(in_data, n, p0, p1);
				if (cur_typed != PREDICTED) begin
					n = cur_typed;
					p0 = cur_e0;
					p1 = cur_e1;
				end
				if (n > 0)
					expected_events.push_back(p0);
				if (n > 1)
					expected_events.push_back(p1);
			end
		end
	end

	// output back-pressure: mostly short runs, now and then a long stall
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			out_stall <= 1'b0;
			stall_run = 0;
		end else if (stall_run != 0) begin
			stall_run--;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 65) begin
				out_stall <= 1'b0;
				stall_run = $urandom_range(0, 6);
			end else if (stall_pick < 93) begin
				out_stall <= 1'b1;
				stall_run = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_run = $urandom_range(8, 40);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL button_click_hold_detector_unit");
			$finish;
		end
	end

	task automatic send_word(input logic cmd, input logic lvl, input int typed,
			input out_word_t e0, input out_word_t e1, input bit nogap);
		int unsigned gap;
		gap = nogap ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{command: cmd, level: lvl};
		cur_typed <= typed;
		cur_e0 <= e0;
		cur_e1 <= e1;
		do
			@(posedge clk);
		while (in_stall);
		words_sent++;
	endtask

	task automatic send_plain(input logic cmd, input logic lvl);
		send_word(cmd, lvl, PREDICTED, '0, '0, 1'b0);
	endtask

	// registers change only with the block drained and settled
	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
	endtask

	initial begin : stimulus
		script_row_t row;
		int unsigned k, presses, ticks, phase_end;
		int p, i;
		out_word_t none;
		none = '0;

		// reset values: window 400, threshold 400, cap 8
		gesture_script.push_back(typed_row(CMD_LEVEL, 1'b0, 0, none, none)); // release while up
		gesture_script.push_back(typed_row(CMD_TICK, 1'b1, 0, none, none));  // no window open
		gesture_script.push_back(typed_row(CMD_LEVEL, 1'b1, 1,
			gesture_event(EV_DOWN, '0, '0, 1'b1), none));
		gesture_script.push_back(typed_row(CMD_LEVEL, 1'b0, 1,
			gesture_event(EV_UP, '0, '0, 1'b1), none));
		// short window and threshold
		gesture_script.push_back(reg_row(REG_CLICK_WINDOW, 16'd3));
		gesture_script.push_back(reg_row(REG_HOLD_THRESH, 16'd5));
		gesture_script.push_back(word_row(CMD_LEVEL, 1'b1, 3));             // presses while held
		gesture_script.push_back(word_row(CMD_TICK, 1'b0, 6));              // window ends while held
		gesture_script.push_back(word_row(CMD_LEVEL, 1'b0, 1));             // long press
		gesture_script.push_back(word_row(CMD_LEVEL, 1'b1, 1));
		gesture_script.push_back(word_row(CMD_LEVEL, 1'b0, 1));
		gesture_script.push_back(word_row(CMD_TICK, 1'b0, 4));              // click while up
		// zero window, zero threshold, no cap
		gesture_script.push_back(reg_row(REG_CLICK_WINDOW, 16'd0));
		gesture_script.push_back(reg_row(REG_HOLD_THRESH, 16'd0));
		gesture_script.push_back(reg_row(REG_COUNT_LIMIT, 16'd0));
		gesture_script.push_back(typed_row(CMD_LEVEL, 1'b1, 1,
			gesture_event(EV_DOWN, '0, '0, 1'b1), none));
		gesture_script.push_back(typed_row(CMD_LEVEL, 1'b0, 2,
			gesture_event(EV_UP, '0, '0, 1'b0), gesture_event(EV_HOLD, 8'd1, '0, 1'b1)));
		gesture_script.push_back(typed_row(CMD_TICK, 1'b0, 1,
			gesture_event(EV_CLICK, 8'd1, '0, 1'b1), none));
		gesture_script.push_back(word_row(CMD_LEVEL, 1'b1, 258));           // count saturates
		gesture_script.push_back(typed_row(CMD_LEVEL, 1'b0, 2,
			gesture_event(EV_UP, '0, '0, 1'b0), gesture_event(EV_HOLD, 8'd255, '0, 1'b1)));
		gesture_script.push_back(typed_row(CMD_TICK, 1'b1, 1,
			gesture_event(EV_CLICK, 8'd255, '0, 1'b1), none));
		// widest settings
		gesture_script.push_back(reg_row(REG_CLICK_WINDOW, 16'hFFFF));
		gesture_script.push_back(reg_row(REG_HOLD_THRESH, 16'hFFFF));
		gesture_script.push_back(reg_row(REG_COUNT_LIMIT, 16'd255));
		gesture_script.push_back(word_row(CMD_LEVEL, 1'b1, 2));
		gesture_script.push_back(word_row(CMD_TICK, 1'b0, 10));
		gesture_script.push_back(word_row(CMD_LEVEL, 1'b0, 1));
		gesture_script.push_back(reg_row(REG_COUNT_LIMIT, 16'd1));
		gesture_script.push_back(word_row(CMD_LEVEL, 1'b1, 3));
		gesture_script.push_back(word_row(CMD_LEVEL, 1'b0, 1));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < gesture_script.size(); i++) begin
			row = gesture_script[i];
			if (row.kind == ROW_REG) begin
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				for (k = 0; k < row.reps; k++)
					send_word(row.cmd, row.lvl, row.typed, row.e0, row.e1, row.reps > 20);
			end
		end

		for (p = 0; p < RAND_PHASES; p++) begin
			write_reg(REG_CLICK_WINDOW, draw_setting(REG_CLICK_WINDOW));
			write_reg(REG_HOLD_THRESH, draw_setting(REG_HOLD_THRESH));
			write_reg(REG_COUNT_LIMIT, draw_setting(REG_COUNT_LIMIT));
			quiet = (p == 2);
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end) begin
				if ($urandom_range(0, 99) < 75) begin
					// multi-press gesture with holds sized around the threshold
					presses = $urandom_range(1, 4);
					for (k = 0; k < presses; k++) begin
						send_plain(CMD_LEVEL, 1'b1);
						if ($urandom_range(0, 9) == 0)
							send_plain(CMD_LEVEL, 1'b1);
						ticks = $urandom_range(0, (thr_cfg > 16'd37) ? 40 : thr_cfg + 3);
						repeat (ticks) send_plain(CMD_TICK, 1'($urandom_range(0, 1)));
						send_plain(CMD_LEVEL, 1'b0);
						ticks = $urandom_range(0, (win_cfg > 16'd28) ? 30 : win_cfg + 2);
						repeat (ticks) send_plain(CMD_TICK, 1'($urandom_range(0, 1)));
					end
					ticks = $urandom_range(0, (win_cfg > 16'd41) ? 45 : win_cfg + 4);
					repeat (ticks) send_plain(CMD_TICK, 1'($urandom_range(0, 1)));
				end else begin
					repeat ($urandom_range(1, 5))
						send_plain(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end
		end
		quiet = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("Run covered %0d input words and %0d register writes.", words_sent, reg_writes);
		$display("Checked %0d events, %0d clicks and %0d holds among them; %0d errors.",
			events_checked, clicks_seen, holds_seen, errors);
		if (errors == 0)
			$display("PASS button_click_hold_detector_unit");
		else
			$display("FAIL button_click_hold_detector_unit");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bchd_pkg.sv
hdl/bchd_core.sv
hdl/bchd_outq.sv
hdl/button_click_hold_detector_unit.sv
verif/tb.sv
